@@ hw/rtl/rbb_pkg.sv @@
// Shared types and constants for the rotated box bounding box pipeline.
`default_nettype none

package rbb_pkg;

  // Fixed-point widths.
  localparam int QW     = 16;  // quaternion component, Q2.14
  localparam int CW     = 32;  // centre and result, Q16.16
  localparam int HW     = 31;  // half size, unsigned Q15.16
  localparam int PW     = 32;  // product of two quaternion components, Q4.28
  localparam int EW     = 35;  // signed matrix entry before rounding
  localparam int AW     = 29;  // rounded absolute matrix entry, Q24
  localparam int MW     = HW + AW;  // half size times matrix entry
  localparam int SW     = MW + 1;   // sum of three such products
  localparam int XW     = SW - 24;  // axis extent, unsigned Q21.16
  localparam int BW     = XW + 2;   // centre plus or minus extent

  localparam logic signed [EW-1:0] ONE_Q28 = EW'(64'sd268435456);
  localparam logic [SW-1:0]        RND_Q24 = SW'(64'd8388608);

  // Quaternion component slots.
  localparam int Q_W = 0;
  localparam int Q_X = 1;
  localparam int Q_Y = 2;
  localparam int Q_Z = 3;

  // Product slots of the first stage.
  localparam int P_XX = 0;
  localparam int P_YY = 1;
  localparam int P_ZZ = 2;
  localparam int P_XY = 3;
  localparam int P_XZ = 4;
  localparam int P_YZ = 5;
  localparam int P_WX = 6;
  localparam int P_WY = 7;
  localparam int P_WZ = 8;

  typedef enum logic {
    SHAPE_SPHERE = 1'b0,
    SHAPE_BOX    = 1'b1
  } shape_t;

  typedef struct packed {
    logic                   req_type;
    logic [3:0][QW-1:0]     quat;
    logic [2:0][CW-1:0]     centre;
    logic [2:0][HW-1:0]     half;
  } in_t;

  typedef struct packed {
    logic                   req_type;
    logic [2:0][CW-1:0]     centre;
    logic [2:0][HW-1:0]     half;
    logic [8:0][PW-1:0]     prod;
  } prod_t;

  typedef struct packed {
    logic                   req_type;
    logic [2:0][CW-1:0]     centre;
    logic [2:0][HW-1:0]     half;
    logic [2:0][2:0][AW-1:0] absm;
  } mat_t;

  typedef struct packed {
    logic                   req_type;
    logic [2:0][CW-1:0]     centre;
    logic [HW-1:0]          radius;
    logic [2:0][2:0][MW-1:0] term;
  } term_t;

  typedef struct packed {
    logic [2:0][CW-1:0]     centre;
    logic [2:0][XW-1:0]     ext;
  } ext_t;

  typedef struct packed {
    logic [2:0][CW-1:0]     lo;
    logic [2:0][CW-1:0]     hi;
  } box_t;

endpackage

`default_nettype wire

@@ hw/rtl/rbb_rot.sv @@
// Quaternion products and rounded absolute rotation matrix, two pipeline stages.
`default_nettype none

module rbb_rot import rbb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic up_valid,
  output logic      up_ready,
  input  wire in_t  up_data,
  output logic      dn_valid,
  input  wire logic dn_ready,
  output mat_t      dn_data
);

  logic  s1_v_r;
  prod_t s1_r;
  prod_t s1_nxt;
  logic  s1_rdy;
  logic  s2_v_r;
  mat_t  s2_r;
  mat_t  s2_nxt;
  logic  s2_rdy;

  function automatic logic signed [EW-1:0] ext_p(input logic [PW-1:0] p);
    return EW'($signed(p));
  endfunction

  // Absolute value of a signed Q7.28 entry, rounded half up to Q24.
  function automatic logic [AW-1:0] abs_q24(input logic signed [EW-1:0] m);
    logic [EW-1:0] a;
    logic [EW-1:0] t;
    a = m[EW-1] ? EW'(-m) : EW'(m);
    t = a + EW'(8);
    return t[AW+3:4];
  endfunction

  assign s2_rdy   = !s2_v_r || dn_ready;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign up_ready = s1_rdy;
  assign dn_valid = s2_v_r;
  assign dn_data  = s2_r;

  always_comb begin
    logic signed [QW-1:0] qw;
    logic signed [QW-1:0] qx;
    logic signed [QW-1:0] qy;
    logic signed [QW-1:0] qz;
    qw = $signed(up_data.quat[Q_W]);
    qx = $signed(up_data.quat[Q_X]);
    qy = $signed(up_data.quat[Q_Y]);
    qz = $signed(up_data.quat[Q_Z]);
    s1_nxt.req_type   = up_data.req_type;
    s1_nxt.centre     = up_data.centre;
    s1_nxt.half       = up_data.half;
    s1_nxt.prod[P_XX] = PW'(qx * qx);
    s1_nxt.prod[P_YY] = PW'(qy * qy);
    s1_nxt.prod[P_ZZ] = PW'(qz * qz);
    s1_nxt.prod[P_XY] = PW'(qx * qy);
    s1_nxt.prod[P_XZ] = PW'(qx * qz);
    s1_nxt.prod[P_YZ] = PW'(qy * qz);
    s1_nxt.prod[P_WX] = PW'(qw * qx);
    s1_nxt.prod[P_WY] = PW'(qw * qy);
    s1_nxt.prod[P_WZ] = PW'(qw * qz);
  end

  always_comb begin
    logic signed [EW-1:0] pxx;
    logic signed [EW-1:0] pyy;
    logic signed [EW-1:0] pzz;
    logic signed [EW-1:0] pxy;
    logic signed [EW-1:0] pxz;
    logic signed [EW-1:0] pyz;
    logic signed [EW-1:0] pwx;
    logic signed [EW-1:0] pwy;
    logic signed [EW-1:0] pwz;
    pxx = ext_p(s1_r.prod[P_XX]);
    pyy = ext_p(s1_r.prod[P_YY]);
    pzz = ext_p(s1_r.prod[P_ZZ]);
    pxy = ext_p(s1_r.prod[P_XY]);
    pxz = ext_p(s1_r.prod[P_XZ]);
    pyz = ext_p(s1_r.prod[P_YZ]);
    pwx = ext_p(s1_r.prod[P_WX]);
    pwy = ext_p(s1_r.prod[P_WY]);
    pwz = ext_p(s1_r.prod[P_WZ]);
    s2_nxt.req_type   = s1_r.req_type;
    s2_nxt.centre     = s1_r.centre;
    s2_nxt.half       = s1_r.half;
    s2_nxt.absm[0][0] = abs_q24(ONE_Q28 - ((pyy + pzz) <<< 1));
    s2_nxt.absm[0][1] = abs_q24((pxy - pwz) <<< 1);
    s2_nxt.absm[0][2] = abs_q24((pxz + pwy) <<< 1);
    s2_nxt.absm[1][0] = abs_q24((pxy + pwz) <<< 1);
    s2_nxt.absm[1][1] = abs_q24(ONE_Q28 - ((pxx + pzz) <<< 1));
    s2_nxt.absm[1][2] = abs_q24((pyz - pwx) <<< 1);
    s2_nxt.absm[2][0] = abs_q24((pxz - pwy) <<< 1);
    s2_nxt.absm[2][1] = abs_q24((pyz + pwx) <<< 1);
    s2_nxt.absm[2][2] = abs_q24(ONE_Q28 - ((pxx + pyy) <<< 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= up_valid;
      if (s2_rdy) s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && up_valid) s1_r <= s1_nxt;
    if (s2_rdy && s1_v_r) s2_r <= s2_nxt;
  end

endmodule

`default_nettype wire

@@ hw/rtl/rbb_ext.sv @@
// Half size by matrix entry products and per-axis extent sums, two pipeline stages.
`default_nettype none

module rbb_ext import rbb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic up_valid,
  output logic      up_ready,
  input  wire mat_t up_data,
  output logic      dn_valid,
  input  wire logic dn_ready,
  output ext_t      dn_data
);

  logic  s3_v_r;
  term_t s3_r;
  term_t s3_nxt;
  logic  s3_rdy;
  logic  s4_v_r;
  ext_t  s4_r;
  ext_t  s4_nxt;
  logic  s4_rdy;

  assign s4_rdy   = !s4_v_r || dn_ready;
  assign s3_rdy   = !s3_v_r || s4_rdy;
  assign up_ready = s3_rdy;
  assign dn_valid = s4_v_r;
  assign dn_data  = s4_r;

  always_comb begin
    s3_nxt.req_type = up_data.req_type;
    s3_nxt.centre   = up_data.centre;
    s3_nxt.radius   = up_data.half[0];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s3_nxt.term[i][j] = MW'(up_data.half[j]) * MW'(up_data.absm[i][j]);
      end
    end
  end

  // For boxes the extent sum is exact and is rounded half up back to Q16.16; spheres take half[0].
  always_comb begin
    logic [SW-1:0] s;
    s = '0;
    s4_nxt.centre = s3_r.centre;
    for (int i = 0; i < 3; i++) begin
      s = SW'(s3_r.term[i][0]) + SW'(s3_r.term[i][1]) + SW'(s3_r.term[i][2]) + RND_Q24;
      if (s3_r.req_type == SHAPE_BOX) begin
        s4_nxt.ext[i] = s[SW-1:24];
      end else begin
        s4_nxt.ext[i] = XW'(s3_r.radius);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (s3_rdy) s3_v_r <= up_valid;
      if (s4_rdy) s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy && up_valid) s3_r <= s3_nxt;
    if (s4_rdy && s3_v_r) s4_r <= s4_nxt;
  end

endmodule

`default_nettype wire

@@ hw/rtl/rbb_bound.sv @@
// Saturating min and max corners and the output register stage.
`default_nettype none

module rbb_bound import rbb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic up_valid,
  output logic      up_ready,
  input  wire ext_t up_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output box_t      out_box
);

  logic out_v_r;
  box_t box_r;
  box_t box_nxt;
  logic rdy;

  function automatic logic [CW-1:0] sat32(input logic signed [BW-1:0] v);
    logic [CW-1:0] r;
    if (v[BW-1:CW-1] == {(BW-CW+1){v[BW-1]}}) begin
      r = v[CW-1:0];
    end else if (v[BW-1]) begin
      r = {1'b1, {(CW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CW-1){1'b1}}};
    end
    return r;
  endfunction

  assign rdy       = !out_v_r || !out_stall;
  assign up_ready  = rdy;
  assign out_valid = out_v_r;
  assign out_box   = box_r;

  always_comb begin
    logic signed [BW-1:0] c;
    logic signed [BW-1:0] e;
    for (int i = 0; i < 3; i++) begin
      c = BW'($signed(up_data.centre[i]));
      e = $signed({2'b00, up_data.ext[i]});
      box_nxt.lo[i] = sat32(c - e);
      box_nxt.hi[i] = sat32(c + e);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (rdy) begin
      out_v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && up_valid) box_r <= box_nxt;
  end

endmodule

`default_nettype wire

@@ hw/rtl/rotated_box_bounding_box.sv @@
// Throughput: one transaction per cycle while the output is not stalled; five register
// stages (products, matrix, extent products, extent sums, saturated corners) each hold
// one transaction.
// Every stage advances independently, so bubbles close up while the output stalls.
// Reset (rst_n low, synchronous) clears all valid bits; payload registers are not reset.
`default_nettype none

module rotated_box_bounding_box import rbb_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_req_type,
  input  wire logic signed [15:0]   in_quat_w,
  input  wire logic signed [15:0]   in_quat_x,
  input  wire logic signed [15:0]   in_quat_y,
  input  wire logic signed [15:0]   in_quat_z,
  input  wire logic signed [31:0]   in_centre_x,
  input  wire logic signed [31:0]   in_centre_y,
  input  wire logic signed [31:0]   in_centre_z,
  input  wire logic [30:0]          in_half_x,
  input  wire logic [30:0]          in_half_y,
  input  wire logic [30:0]          in_half_z,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [31:0]        out_min_x,
  output logic signed [31:0]        out_min_y,
  output logic signed [31:0]        out_min_z,
  output logic signed [31:0]        out_max_x,
  output logic signed [31:0]        out_max_y,
  output logic signed [31:0]        out_max_z
);

  in_t  in_data;
  logic in_ready;
  mat_t mat_data;
  logic mat_valid;
  logic mat_ready;
  ext_t ext_data;
  logic ext_valid;
  logic ext_ready;
  box_t box;

  always_comb begin
    in_data.req_type    = in_req_type;
    in_data.quat[Q_W]   = in_quat_w;
    in_data.quat[Q_X]   = in_quat_x;
    in_data.quat[Q_Y]   = in_quat_y;
    in_data.quat[Q_Z]   = in_quat_z;
    in_data.centre[0]   = in_centre_x;
    in_data.centre[1]   = in_centre_y;
    in_data.centre[2]   = in_centre_z;
    in_data.half[0]     = in_half_x;
    in_data.half[1]     = in_half_y;
    in_data.half[2]     = in_half_z;
  end

  assign in_stall = !in_ready;

  rbb_rot u_rot (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_data),
    .dn_valid (mat_valid),
    .dn_ready (mat_ready),
    .dn_data  (mat_data)
  );

  rbb_ext u_ext (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mat_valid),
    .up_ready (mat_ready),
    .up_data  (mat_data),
    .dn_valid (ext_valid),
    .dn_ready (ext_ready),
    .dn_data  (ext_data)
  );

  rbb_bound u_bound (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (ext_valid),
    .up_ready  (ext_ready),
    .up_data   (ext_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_box   (box)
  );

  assign out_min_x = box.lo[0];
  assign out_min_y = box.lo[1];
  assign out_min_z = box.lo[2];
  assign out_max_x = box.hi[0];
  assign out_max_y = box.hi[1];
  assign out_max_z = box.hi[2];

endmodule

`default_nettype wire

@@ tb/rotated_box_bounding_box_tb.sv @@
// Testbench for the rotated box bounding box pipeline: checks every bounding box against a model.
`timescale 1ns / 100ps

module rotated_box_bounding_box_tb;
  import rbb_pkg::*;

  localparam longint UNIT_Q28   = longint'(1) << 28;
  localparam longint HALF_Q24   = longint'(1) << 23;
  localparam longint COORD_MAX  = 64'sd2147483647;
  localparam longint COORD_MIN  = -64'sd2147483648;
  localparam int     RAND_ITEMS = 1330;
  localparam int     DRAIN_CYCLES = 20;

  typedef struct packed {
    shape_t             kind;
    logic signed [15:0] qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [30:0]        hx;
    logic [30:0]        hy;
    logic [30:0]        hz;
  } shape_req_t;

  typedef struct packed {
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic signed [31:0] max_z;
  } aabb_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_req_type = 1'b0;
  logic signed [15:0] in_quat_w = '0;
  logic signed [15:0] in_quat_x = '0;
  logic signed [15:0] in_quat_y = '0;
  logic signed [15:0] in_quat_z = '0;
  logic signed [31:0] in_centre_x = '0;
  logic signed [31:0] in_centre_y = '0;
  logic signed [31:0] in_centre_z = '0;
  logic [30:0]        in_half_x = '0;
  logic [30:0]        in_half_y = '0;
  logic [30:0]        in_half_z = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_min_x;
  logic signed [31:0] out_min_y;
  logic signed [31:0] out_min_z;
  logic signed [31:0] out_max_x;
  logic signed [31:0] out_max_y;
  logic signed [31:0] out_max_z;

  shape_req_t pending_shapes [$];
  aabb_t      expected_boxes [$];
  shape_req_t cur_shape;
  aabb_t      want_box;
  int         mismatches = 0;
  int         burst_left = 0;
  int         gap_left = 0;
  int         stall_mode = 0;
  int         stall_left = 0;

  rotated_box_bounding_box dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req_type(in_req_type),
    .in_quat_w  (in_quat_w),
    .in_quat_x  (in_quat_x),
    .in_quat_y  (in_quat_y),
    .in_quat_z  (in_quat_z),
    .in_centre_x(in_centre_x),
    .in_centre_y(in_centre_y),
    .in_centre_z(in_centre_z),
    .in_half_x  (in_half_x),
    .in_half_y  (in_half_y),
    .in_half_z  (in_half_z),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_min_x  (out_min_x),
    .out_min_y  (out_min_y),
    .out_min_z  (out_min_z),
    .out_max_x  (out_max_x),
    .out_max_y  (out_max_y),
    .out_max_z  (out_max_z)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > COORD_MAX) return 32'sh7FFFFFFF;
    if (v < COORD_MIN) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Box extents come from the rotation matrix built from the raw quaternion, with each absolute
  // entry rounded to Q24 and the summed extent rounded back to Q16.16; spheres use hx as extent.
  function automatic aabb_t bound_box(shape_req_t r);
    longint          qw, qx, qy, qz;
    longint          m [9];
    longint unsigned mag [9];
    longint unsigned hl [3];
    longint          ctr [3];
    longint          ext [3];
    longint unsigned sum;
    aabb_t           b;
    qw = longint'(r.qw);
    qx = longint'(r.qx);
    qy = longint'(r.qy);
    qz = longint'(r.qz);
    ctr[0] = longint'(r.cx);
    ctr[1] = longint'(r.cy);
    ctr[2] = longint'(r.cz);
    hl[0] = {33'd0, r.hx};
    hl[1] = {33'd0, r.hy};
    hl[2] = {33'd0, r.hz};
    if (r.kind == SHAPE_SPHERE) begin
      for (int i = 0; i < 3; i++) ext[i] = longint'(hl[0]);
    end else begin
      m[0] = UNIT_Q28 - 2 * (qy * qy + qz * qz);
      m[1] = 2 * (qx * qy - qw * qz);
      m[2] = 2 * (qx * qz + qw * qy);
      m[3] = 2 * (qx * qy + qw * qz);
      m[4] = UNIT_Q28 - 2 * (qx * qx + qz * qz);
      m[5] = 2 * (qy * qz - qw * qx);
      m[6] = 2 * (qx * qz - qw * qy);
      m[7] = 2 * (qy * qz + qw * qx);
      m[8] = UNIT_Q28 - 2 * (qx * qx + qy * qy);
      for (int i = 0; i < 9; i++) mag[i] = ((m[i] < 0 ? -m[i] : m[i]) + 8) >> 4;
      for (int i = 0; i < 3; i++) begin
        sum = hl[0] * mag[3 * i] + hl[1] * mag[3 * i + 1] + hl[2] * mag[3 * i + 2];
        ext[i] = longint'((sum + longint'(HALF_Q24)) >> 24);
      end
    end
    b.min_x = clamp32(ctr[0] - ext[0]);
    b.min_y = clamp32(ctr[1] - ext[1]);
    b.min_z = clamp32(ctr[2] - ext[2]);
    b.max_x = clamp32(ctr[0] + ext[0]);
    b.max_y = clamp32(ctr[1] + ext[1]);
    b.max_z = clamp32(ctr[2] + ext[2]);
    return b;
  endfunction

  task automatic add_shape(input shape_t k, input logic [15:0] qw, qx, qy, qz,
                           input logic [31:0] cx, cy, cz, input logic [30:0] hx, hy, hz);
    shape_req_t r;
    r.kind = k;
    r.qw = qw;
    r.qx = qx;
    r.qy = qy;
    r.qz = qz;
    r.cx = cx;
    r.cy = cy;
    r.cz = cz;
    r.hx = hx;
    r.hy = hy;
    r.hz = hz;
    pending_shapes.push_back(r);
  endtask

  function automatic logic [30:0] rand_len();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 31'h7FFFFFFF;
      2, 3: return 31'($urandom);
      default: return 31'($urandom_range(0, 1 << 22));
    endcase
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 9))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2, 3: return $urandom;
      default: return 32'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
    endcase
  endfunction

  function automatic logic [15:0] axis_comp();
    case ($urandom_range(0, 4))
      0: return 16'sd0;
      1: return 16'sd16384;
      2: return -16'sd16384;
      3: return 16'sd11585;
      default: return -16'sd11585;
    endcase
  endfunction

  task automatic add_random_shape();
    real         v [4];
    real         norm;
    logic [15:0] q [4];
    int          mode;
    mode = $urandom_range(0, 9);
    if (mode < 5) begin
      // Roughly unit quaternions, the normal case for a real rotation.
      norm = 0.0;
      for (int i = 0; i < 4; i++) begin
        v[i] = real'(int'($urandom_range(0, 65534)) - 32767) / 32767.0;
        norm = norm + v[i] * v[i];
      end
      norm = $sqrt(norm);
      if (norm < 0.001) begin
        v[0] = 1.0;
        v[1] = 0.0;
        v[2] = 0.0;
        v[3] = 0.0;
        norm = 1.0;
      end
      for (int i = 0; i < 4; i++) q[i] = 16'($rtoi(v[i] / norm * 16384.0));
    end else if (mode < 8) begin
      for (int i = 0; i < 4; i++) q[i] = 16'($urandom);
    end else begin
      for (int i = 0; i < 4; i++) q[i] = axis_comp();
    end
    add_shape(($urandom_range(0, 3) == 0) ? SHAPE_SPHERE : SHAPE_BOX, q[0], q[1], q[2], q[3],
              rand_pos(), rand_pos(), rand_pos(), rand_len(), rand_len(), rand_len());
  endtask

  task automatic compare_coord(input string tag, input logic signed [31:0] want_v, got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %0d got %0d", $time, tag, want_v, got_v);
      mismatches++;
    end
  endtask

  // Sender: bursts of transactions separated by idle gaps of random length.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_boxes.push_back(bound_box(cur_shape));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_shapes.size() > 0) begin
          cur_shape = pending_shapes.pop_front();
          in_req_type <= cur_shape.kind;
          in_quat_w <= cur_shape.qw;
          in_quat_x <= cur_shape.qx;
          in_quat_y <= cur_shape.qy;
          in_quat_z <= cur_shape.qz;
          in_centre_x <= cur_shape.cx;
          in_centre_y <= cur_shape.cy;
          in_centre_z <= cur_shape.cz;
          in_half_x <= cur_shape.hx;
          in_half_y <= cur_shape.hy;
          in_half_z <= cur_shape.hz;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted box and stalls in modes of none, light and heavy.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_boxes.size() == 0) begin
          $display("%0t: result transaction with none outstanding", $time);
          mismatches++;
        end else begin
          want_box = expected_boxes.pop_front();
          compare_coord("min_x", want_box.min_x, out_min_x);
          compare_coord("min_y", want_box.min_y, out_min_y);
          compare_coord("min_z", want_box.min_z, out_min_z);
          compare_coord("max_x", want_box.max_x, out_max_x);
          compare_coord("max_y", want_box.max_y, out_max_y);
          compare_coord("max_z", want_box.max_z, out_max_z);
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(16, 200);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  initial begin
    // Spheres: extremes, saturation both ways, and ignored rotation and half sizes.
    add_shape(SHAPE_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_shape(SHAPE_SPHERE, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
              31'h7FFFFFFF, 0, 0);
    add_shape(SHAPE_SPHERE, 0, 0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000,
              31'h7FFFFFFF, 0, 0);
    add_shape(SHAPE_SPHERE, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 32'd65536, 0,
              32'hFFFF0000, 31'd98304, 31'h7FFFFFFF, 31'h7FFFFFFF);
    add_shape(SHAPE_SPHERE, 16'd16384, 0, 0, 0, 32'hFFFFFFFF, 1, 0, 1, 5, 7);
    // Boxes: identity, zero quaternion, axis turns and non-unit quaternions.
    add_shape(SHAPE_BOX, 16'd16384, 0, 0, 0, 0, 0, 0, 31'd65536, 31'd131072, 31'd196608);
    add_shape(SHAPE_BOX, 0, 0, 0, 0, 32'd1000, 32'hFFFFFC18, 0, 31'd65536, 31'd131072,
              31'd196608);
    add_shape(SHAPE_BOX, 16'd11585, 0, 0, 16'd11585, 0, 0, 0, 31'd65536, 31'd131072,
              31'd196608);
    add_shape(SHAPE_BOX, 16'd11585, 0, 16'd11585, 0, 0, 0, 0, 1, 1, 1);
    add_shape(SHAPE_BOX, 0, 16'd16384, 0, 0, 32'd12345, 0, 0, 31'd65536, 31'd65536,
              31'd65536);
    add_shape(SHAPE_BOX, 0, 16'h8000, 0, 0, 0, 0, 0, 31'd65536, 31'd3, 31'd65536);
    add_shape(SHAPE_BOX, 16'd8192, 0, 0, 0, 0, 0, 0, 31'd65536, 31'd65536, 31'd65536);
    add_shape(SHAPE_BOX, 0, 16'd16384, 16'd16384, 16'd16384, 0, 0, 0, 31'd100, 31'd200,
              31'd300);
    add_shape(SHAPE_BOX, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 0, 0, 0, 31'd4096,
              31'd8192, 31'd16384);
    // Saturation with the largest quaternions and half sizes.
    add_shape(SHAPE_BOX, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h7FFFFFFF,
              32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
    add_shape(SHAPE_BOX, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'h80000000,
              32'h80000000, 32'h80000000, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
    add_shape(SHAPE_BOX, 16'd16384, 0, 0, 0, 0, 0, 0, 31'h7FFFFFFF, 31'h7FFFFFFF,
              31'h7FFFFFFF);
    add_shape(SHAPE_BOX, 16'd16384, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 0);
    add_shape(SHAPE_BOX, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h80000000,
              32'h7FFFFFFF, 0, 31'd65536, 31'd65536, 31'd65536);
    for (int n = 0; n < RAND_ITEMS; n++) add_random_shape();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_shapes.size() > 0 || in_valid || expected_boxes.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule
